// ----- rtl/brf_pkg.sv -----
// ----------------------------------------------------------------------------
// brf_pkg
// Shared types and constants for the byte ring fifo with search.
// ----------------------------------------------------------------------------
package brf_pkg;

  // width of counts, positions and capacity
  localparam int unsigned CNT_W  = 7;
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned REQ_W  = 3;

  // request codes; the codes above clear are no-ops
  typedef enum logic [REQ_W-1:0] {
    REQ_WRITE  = 3'd0,
    REQ_READ   = 3'd1,
    REQ_PEEK   = 3'd2,
    REQ_SEARCH = 3'd3,
    REQ_CLEAR  = 3'd4
  } brf_req_e;

  // one result transaction, first member in the highest bits
  typedef struct packed {
    logic              out_valid;
    logic [BYTE_W-1:0] out_byte;
    logic [CNT_W-1:0]  free_space;
    logic [CNT_W-1:0]  fill_count;
    logic              found;
    logic              write_accepted;
    logic              data_valid;
    logic [BYTE_W-1:0] data_out;
  } brf_res_t;

endpackage

// ----- rtl/brf_ram.sv -----
// ----------------------------------------------------------------------------
// brf_ram
// Generic simple dual port ram, one write port and one registered read port.
// ----------------------------------------------------------------------------
module brf_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/brf_ctrl.sv -----
// ----------------------------------------------------------------------------
// brf_ctrl
// Request sequencer: ring pointers, storage ram accesses and the search walk.
// ----------------------------------------------------------------------------
module brf_ctrl #(
  parameter int unsigned DEPTH = 64
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // configuration
  input  logic [brf_pkg::CNT_W-1:0]   cap_i,
  input  logic                        ovf_en_i,
  input  logic                        clr_i,
  // request side
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [brf_pkg::REQ_W-1:0]   in_req_i,
  input  logic [brf_pkg::BYTE_W-1:0]  in_data_i,
  // result side
  input  logic                        res_free_i,
  output logic                        res_valid_o,
  output brf_pkg::brf_res_t           res_o
);

  localparam int unsigned AW = $clog2(DEPTH);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WAIT,
    ST_SRCH,
    ST_HOLD
  } state_e;

  state_e                      state_q, state_d;
  logic [brf_pkg::CNT_W-1:0]   head_q, head_d;
  logic [brf_pkg::CNT_W-1:0]   held_q, held_d;
  logic [brf_pkg::CNT_W-1:0]   ptr_q, ptr_d;
  logic [brf_pkg::CNT_W-1:0]   cmp_q, cmp_d;
  logic [brf_pkg::BYTE_W-1:0]  key_q, key_d;
  logic                        dst_q, dst_d;
  brf_pkg::brf_res_t           pend_q, pend_d;

  logic                        accept;
  logic [brf_pkg::CNT_W-1:0]   head_inc;
  logic [brf_pkg::CNT_W-1:0]   ptr_inc;
  logic [brf_pkg::CNT_W:0]     tail_sum;
  logic [brf_pkg::CNT_W-1:0]   tail_pos;
  logic                        hit;
  logic                        last;
  logic                        we;
  logic                        re;
  logic [AW-1:0]               waddr;
  logic [AW-1:0]               raddr;
  logic [brf_pkg::BYTE_W-1:0]  rdata;
  brf_pkg::brf_res_t           res_imm;
  brf_pkg::brf_res_t           byte_res;
  brf_pkg::brf_res_t           srch_res;
  logic                        go_wait;
  logic                        go_srch;

  // storage
  brf_ram #(
    .WIDTH (brf_pkg::BYTE_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (in_data_i),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // no request is taken in the cycle that a capacity write empties the ring
  assign in_ready_o = (state_q == ST_IDLE) && res_free_i && !clr_i;
  assign accept     = in_valid_i && in_ready_o;

  // ring arithmetic, positions stay below capacity
  assign head_inc = (head_q + 1'b1 == cap_i) ? '0 : head_q + 1'b1;
  assign ptr_inc  = (ptr_q + 1'b1 == cap_i) ? '0 : ptr_q + 1'b1;
  assign tail_sum = {1'b0, head_q} + {1'b0, held_q};
  assign tail_pos = (tail_sum >= {1'b0, cap_i}) ? brf_pkg::CNT_W'(tail_sum - {1'b0, cap_i})
                                                : tail_sum[brf_pkg::CNT_W-1:0];
  assign waddr    = AW'(tail_pos);

  // search compare against the entry read last cycle
  assign hit  = (rdata == key_q);
  assign last = (cmp_q + 1'b1 == held_q);

  // pending result completed with the ram byte
  always_comb begin
    byte_res = pend_q;
    if (dst_q) begin
      byte_res.out_byte = rdata;
    end else begin
      byte_res.data_out = rdata;
    end
    srch_res       = pend_q;
    srch_res.found = hit;
  end

  // sequencer
  always_comb begin
    state_d     = state_q;
    head_d      = head_q;
    held_d      = held_q;
    ptr_d       = ptr_q;
    cmp_d       = cmp_q;
    key_d       = key_q;
    dst_d       = dst_q;
    pend_d      = pend_q;
    we          = 1'b0;
    re          = 1'b0;
    raddr       = AW'(head_q);
    res_valid_o = 1'b0;
    res_o       = pend_q;
    res_imm     = '0;
    go_wait     = 1'b0;
    go_srch     = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (clr_i) begin
          head_d = '0;
          held_d = '0;
        end else if (accept) begin
          unique case (in_req_i)
            brf_pkg::REQ_WRITE: begin
              if (held_q < cap_i) begin
                res_imm.write_accepted = 1'b1;
                if (cap_i == brf_pkg::CNT_W'(1) && ovf_en_i) begin
                  // pass-through
                  res_imm.out_byte  = in_data_i;
                  res_imm.out_valid = 1'b1;
                end else begin
                  we     = 1'b1;
                  held_d = held_q + 1'b1;
                  if (ovf_en_i && (held_q + 1'b1 == cap_i)) begin
                    // buffer filled: evict the oldest byte
                    re                = 1'b1;
                    head_d            = head_inc;
                    held_d            = held_q;
                    res_imm.out_valid = 1'b1;
                    dst_d             = 1'b1;
                    go_wait           = 1'b1;
                  end
                end
              end
            end
            brf_pkg::REQ_READ: begin
              if (held_q != '0) begin
                re                 = 1'b1;
                head_d             = head_inc;
                held_d             = held_q - 1'b1;
                res_imm.data_valid = 1'b1;
                dst_d              = 1'b0;
                go_wait            = 1'b1;
              end
            end
            brf_pkg::REQ_PEEK: begin
              if (held_q != '0) begin
                re                 = 1'b1;
                res_imm.data_valid = 1'b1;
                dst_d              = 1'b0;
                go_wait            = 1'b1;
              end
            end
            brf_pkg::REQ_SEARCH: begin
              if (held_q != '0) begin
                re      = 1'b1;
                ptr_d   = head_inc;
                cmp_d   = '0;
                key_d   = in_data_i;
                go_srch = 1'b1;
              end
            end
            brf_pkg::REQ_CLEAR: begin
              head_d = '0;
              held_d = '0;
            end
            default: begin
            end
          endcase
          res_imm.fill_count = held_d;
          res_imm.free_space = cap_i - held_d;
          if (go_wait) begin
            pend_d  = res_imm;
            state_d = ST_WAIT;
          end else if (go_srch) begin
            pend_d  = res_imm;
            state_d = ST_SRCH;
          end else begin
            res_valid_o = 1'b1;
            res_o       = res_imm;
          end
        end
      end
      ST_WAIT: begin
        pend_d = byte_res;
        res_o  = byte_res;
        if (res_free_i) begin
          res_valid_o = 1'b1;
          state_d     = ST_IDLE;
        end else begin
          state_d = ST_HOLD;
        end
      end
      ST_SRCH: begin
        if (hit || last) begin
          pend_d = srch_res;
          res_o  = srch_res;
          if (res_free_i) begin
            res_valid_o = 1'b1;
            state_d     = ST_IDLE;
          end else begin
            state_d = ST_HOLD;
          end
        end else begin
          // next entry of the walk
          re    = 1'b1;
          raddr = AW'(ptr_q);
          ptr_d = ptr_inc;
          cmp_d = cmp_q + 1'b1;
        end
      end
      ST_HOLD: begin
        if (res_free_i) begin
          res_valid_o = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // state, pointer and counter registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      head_q  <= '0;
      held_q  <= '0;
      ptr_q   <= '0;
      cmp_q   <= '0;
      dst_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      held_q  <= held_d;
      ptr_q   <= ptr_d;
      cmp_q   <= cmp_d;
      dst_q   <= dst_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    key_q  <= key_d;
    pend_q <= pend_d;
  end

endmodule

// ----- rtl/byte_ring_fifo_with_search.sv -----
// ----------------------------------------------------------------------------
// byte_ring_fifo_with_search: write, clear and no-op results appear in the cycle after
// the transaction; read, peek and evicting writes wait for the ram read first, a search
// for its walk of up to fill_count entries (shorter on a hit). Simple requests sustain
// 1 per cycle while the result stream is not stalled; others hold off input until done.
// Reset empties the ring, capacity min(64, DEPTH), overflow port off; no clearing pass.
// ----------------------------------------------------------------------------
module byte_ring_fifo_with_search #(
  parameter int unsigned DEPTH = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // request stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // data_in[7:0]
  input  logic [2:0]  s_axis_tuser,   // req_type[2:0]
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // data_out[7:0], data_valid[8], write_accepted[9],
                                      // found[10], fill_count[17:11], free_space[24:18],
                                      // out_byte[32:25], out_valid[33], zero[39:34]
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam logic [brf_pkg::CNT_W-1:0] CapReset =
    (DEPTH < 64) ? brf_pkg::CNT_W'(DEPTH) : brf_pkg::CNT_W'(64);
  localparam logic RegCapacity = 1'b0;
  localparam logic RegOvfEnable = 1'b1;

  logic [brf_pkg::CNT_W-1:0] cap_q, cap_d;
  logic                      ovf_q;
  logic                      cfg_wr;
  logic                      cap_wr;
  logic [brf_pkg::CNT_W-1:0] wval;
  logic                      out_free;
  logic                      res_valid;
  brf_pkg::brf_res_t         res;
  logic                      m_tvalid_q;
  brf_pkg::brf_res_t         m_tdata_q;

  // configuration writes, register index from paddr[2]
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign cap_wr = cfg_wr && (paddr[2] == RegCapacity);
  assign wval   = pwdata[brf_pkg::CNT_W-1:0];

  // capacity limited to 1..DEPTH
  always_comb begin
    if (wval == '0) begin
      cap_d = brf_pkg::CNT_W'(1);
    end else if (32'(wval) > DEPTH) begin
      cap_d = brf_pkg::CNT_W'(DEPTH);
    end else begin
      cap_d = wval;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CapReset;
      ovf_q <= 1'b0;
    end else if (cfg_wr) begin
      if (paddr[2] == RegCapacity) begin
        cap_q <= cap_d;
      end else begin
        ovf_q <= pwdata[0];
      end
    end
  end

  // register readback
  always_comb begin
    if (paddr[2] == RegOvfEnable) begin
      prdata = {31'b0, ovf_q};
    end else begin
      prdata = {{(32 - brf_pkg::CNT_W){1'b0}}, cap_q};
    end
  end

  // request sequencer with storage
  brf_ctrl #(
    .DEPTH (DEPTH)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cap_i       (cap_q),
    .ovf_en_i    (ovf_q),
    .clr_i       (cap_wr),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_req_i    (s_axis_tuser),
    .in_data_i   (s_axis_tdata),
    .res_free_i  (out_free),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  // output register
  assign out_free = !m_tvalid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_tvalid_q <= 1'b0;
    end else if (res_valid) begin
      m_tvalid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_tvalid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid) begin
      m_tdata_q <= res;
    end
  end

  assign m_axis_tvalid = m_tvalid_q;
  assign m_axis_tdata  = {{(40 - $bits(brf_pkg::brf_res_t)){1'b0}}, m_tdata_q};

endmodule
